/* rtl/core/slrrip_pkg.sv */
// shared constants and types for the ship-lite rrip replacement block
// no dependencies
`default_nettype none
package slrrip_pkg;
    localparam int NUM_SETS = 2048;
    localparam int NUM_WAYS = 16;
    localparam int SIG_ENTRIES = 64;
    localparam int SET_W = 11;
    localparam int WAY_W = 4;
    localparam int SIG_W = 6;
    localparam int ADDR_W = 64;
    localparam int SET_ROW_W = NUM_WAYS * 2;
    localparam int SIG_ROW_W = NUM_WAYS * SIG_W;
    localparam int CTR_ROW_W = SIG_ENTRIES * 2;
    localparam int CLR_W = SET_W + 1;
    localparam logic [1:0] RRPV_MAX = 2'd3;
    localparam logic [1:0] RRPV_NEAR = 2'd2;
    localparam logic [1:0] CTR_MAX = 2'd3;
    localparam logic [1:0] CTR_INIT = 2'd1;
    localparam logic [ADDR_W-1:0] STRIDE_SMALL = 64'd64;
    localparam logic [ADDR_W-1:0] STRIDE_LARGE = 64'd128;
    localparam logic CMD_FIND = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic clear_en;
        logic [SET_W-1:0] clear_set;
        logic capture;
        logic read_en;
        logic write_en;
    } ctl_cmd_t;
endpackage
`default_nettype wire

/* rtl/core/slrrip_datapath.sv */
// datapath: per-set row memories, stride detector, aging and counter update
// depends on slrrip_pkg
`default_nettype none
module slrrip_datapath (
    input  wire logic aclk,
    input  wire slrrip_pkg::ctl_cmd_t cmd,
    input  wire logic [1:0] thr_level,
    input  wire logic in_command,
    input  wire logic [10:0] in_set,
    input  wire logic [3:0] in_way,
    input  wire logic [63:0] in_addr,
    input  wire logic [5:0] in_sig,
    input  wire logic in_hit,
    output logic [3:0] victim_way,
    output logic set_streaming
);
    import slrrip_pkg::*;

    // one row per set: rrpvs, signatures, counters, previous address, stride, valid
    logic [SET_ROW_W-1:0] rrpv_mem [NUM_SETS];
    logic [SIG_ROW_W-1:0] sig_mem  [NUM_SETS];
    logic [CTR_ROW_W-1:0] ctr_mem  [NUM_SETS];
    logic [ADDR_W+2:0]    adr_mem  [NUM_SETS];

    logic cmd_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIG_W-1:0] sig_reg;
    logic hit_reg;
    logic [SET_ROW_W-1:0] rrpv_row_reg;
    logic [SIG_ROW_W-1:0] sig_row_reg;
    logic [CTR_ROW_W-1:0] ctr_row_reg;
    logic [ADDR_W+2:0] adr_row_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= in_command;
            set_reg <= in_set;
            way_reg <= in_way;
            addr_reg <= in_addr;
            sig_reg <= in_sig;
            hit_reg <= in_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_en) begin
            rrpv_row_reg <= rrpv_mem[set_reg];
            sig_row_reg <= sig_mem[set_reg];
            ctr_row_reg <= ctr_mem[set_reg];
            adr_row_reg <= adr_mem[set_reg];
        end
    end

    // aging: max rrpv across ways, add the gap to every way
    logic [1:0] max_rrpv, gap;
    logic [SET_ROW_W-1:0] aged_row;
    logic [WAY_W-1:0] first_way;
    logic found;
    always_comb begin
        max_rrpv = '0;
        for (int w = 0; w < NUM_WAYS; w++)
            if (rrpv_row_reg[w*2 +: 2] > max_rrpv) max_rrpv = rrpv_row_reg[w*2 +: 2];
        gap = RRPV_MAX - max_rrpv;
        found = 1'b0;
        first_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged_row[w*2 +: 2] = rrpv_row_reg[w*2 +: 2] + gap;
            if (!found && aged_row[w*2 +: 2] == RRPV_MAX) begin
                found = 1'b1;
                first_way = WAY_W'(w);
            end
        end
    end

    // stride detector
    logic [ADDR_W-1:0] prev_addr, delta;
    logic [1:0] stride_old, stride_new;
    logic addr_valid, is_stride;
    always_comb begin
        prev_addr = adr_row_reg[ADDR_W-1:0];
        stride_old = adr_row_reg[ADDR_W+1:ADDR_W];
        addr_valid = adr_row_reg[ADDR_W+2];
        delta = (addr_reg > prev_addr) ? addr_reg - prev_addr : prev_addr - addr_reg;
        is_stride = addr_valid && (delta == STRIDE_SMALL || delta == STRIDE_LARGE);
        if (is_stride) stride_new = (stride_old < CTR_MAX) ? stride_old + 2'd1 : stride_old;
        else stride_new = (stride_old != 2'd0) ? stride_old - 2'd1 : stride_old;
    end

    // block update
    logic [SIG_W-1:0] old_sig;
    logic [1:0] old_ctr, new_sig_ctr;
    logic [CTR_ROW_W-1:0] ctr_upd;
    logic [SET_ROW_W-1:0] rrpv_upd;
    logic [SIG_ROW_W-1:0] sig_upd;
    always_comb begin
        old_sig = sig_row_reg[way_reg*SIG_W +: SIG_W];
        old_ctr = ctr_row_reg[old_sig*2 +: 2];
        ctr_upd = ctr_row_reg;
        rrpv_upd = rrpv_row_reg;
        sig_upd = sig_row_reg;
        if (hit_reg) begin
            rrpv_upd[way_reg*2 +: 2] = 2'd0;
            if (old_ctr < CTR_MAX) ctr_upd[old_sig*2 +: 2] = old_ctr + 2'd1;
        end else begin
            if (old_ctr != 2'd0) ctr_upd[old_sig*2 +: 2] = old_ctr - 2'd1;
            sig_upd[way_reg*SIG_W +: SIG_W] = sig_reg;
        end
        new_sig_ctr = ctr_upd[sig_reg*2 +: 2];
        if (!hit_reg)
            rrpv_upd[way_reg*2 +: 2] = (new_sig_ctr == 2'd0) ? RRPV_MAX : RRPV_NEAR;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            rrpv_mem[cmd.clear_set] <= {NUM_WAYS{RRPV_MAX}};
            sig_mem[cmd.clear_set] <= '0;
            ctr_mem[cmd.clear_set] <= {SIG_ENTRIES{CTR_INIT}};
            adr_mem[cmd.clear_set] <= '0;
        end else if (cmd.write_en) begin
            if (cmd_reg == CMD_FIND) begin
                rrpv_mem[set_reg] <= aged_row;
            end else begin
                rrpv_mem[set_reg] <= rrpv_upd;
                sig_mem[set_reg] <= sig_upd;
                ctr_mem[set_reg] <= ctr_upd;
                adr_mem[set_reg] <= {1'b1, stride_new, addr_reg};
            end
        end
    end

    always_comb begin
        victim_way = (cmd_reg == CMD_FIND) ? first_way : '0;
        set_streaming = ((cmd_reg == CMD_FIND) ? stride_old : stride_new) >= thr_level;
    end
endmodule
`default_nettype wire

/* rtl/core/slrrip_ctrl.sv */
// controller: clearing sweep, read then write-back sequencing, output register
// depends on slrrip_pkg
`default_nettype none
module slrrip_ctrl (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  wire logic m_tready,
    output slrrip_pkg::ctl_cmd_t cmd,
    output logic load_out
);
    import slrrip_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic mvalid_reg, mvalid_next;

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        mvalid_next = mvalid_reg;
        cmd = '0;
        cmd.clear_set = clr_reg[SET_W-1:0];
        load_out = 1'b0;
        s_tready = (state_reg == ST_IDLE);
        if (m_tready) mvalid_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(NUM_SETS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_en = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.write_en = 1'b1;
                    load_out = 1'b1;
                    mvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
endmodule
`default_nettype wire

/* rtl/core/ship_lite_rrip_replacement_top.sv */
// a transaction is captured, its set rows are read, then written back with the result loaded
// into the output register; s_tready stays low until the write-back, so a new one waits
// the write-back waits while an earlier result is still held in the output register
// reset: synchronous active-low; afterwards a clearing pass walks all 2048 set rows,
// during which s_tready stays low; stream threshold resets to 3
// depends on slrrip_pkg, slrrip_ctrl, slrrip_datapath
`default_nettype none
module ship_lite_rrip_replacement_top (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic s_tvalid,
    output logic s_tready,
    // tdata: set_index[10:0], way_index[14:11], phys_address[78:15], signature[84:79], was_hit[85]
    input  wire logic [87:0] s_tdata,
    // tuser: command
    input  wire logic [0:0] s_tuser,
    output logic m_tvalid,
    input  wire logic m_tready,
    // tdata: victim_way[3:0], set_streaming[4]
    output logic [7:0] m_tdata
);
    import slrrip_pkg::*;

    logic [1:0] thr_reg;
    ctl_cmd_t cmd;
    logic load_out;
    logic [3:0] victim_way;
    logic set_streaming;
    logic [4:0] out_reg;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= 2'd3;
        else if (cfg_we) thr_reg <= cfg_wdata;
    end

    slrrip_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .load_out(load_out)
    );

    slrrip_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .thr_level(thr_reg),
        .in_command(s_tuser[0]), .in_set(s_tdata[10:0]), .in_way(s_tdata[14:11]),
        .in_addr(s_tdata[78:15]), .in_sig(s_tdata[84:79]), .in_hit(s_tdata[85]),
        .victim_way(victim_way), .set_streaming(set_streaming)
    );

    // output register holds the result until taken
    always_ff @(posedge aclk) begin
        if (load_out) out_reg <= {set_streaming, victim_way};
    end

    assign m_tdata = {3'b000, out_reg};
endmodule
`default_nettype wire

/* sim/tb_ship_lite_rrip_replacement_top.sv */
// self-checking testbench for ship_lite_rrip_replacement_top: replacement and stride prediction
// depends on slrrip_pkg and the rtl of ship_lite_rrip_replacement_top
`default_nettype none
module tb_ship_lite_rrip_replacement_top;
    import slrrip_pkg::*;

    typedef struct packed {
        logic              cmd;
        logic [SET_W-1:0]  set_idx;
        logic [WAY_W-1:0]  way;
        logic [ADDR_W-1:0] addr;
        logic [SIG_W-1:0]  sig;
        logic              hit;
    } access_t;

    typedef struct packed {
        logic [3:0] victim;
        logic       streaming;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [87:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;

    ship_lite_rrip_replacement_top i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // predictor state, mirrors the block's memories
    logic [1:0]        rrpv_mem [NUM_SETS*NUM_WAYS];
    logic [1:0]        reuse_ctr [NUM_SETS*SIG_ENTRIES];
    logic [SIG_W-1:0]  blk_sig [NUM_SETS*NUM_WAYS];
    logic [ADDR_W-1:0] prev_addr [NUM_SETS];
    logic [1:0]        stride_cnt [NUM_SETS];
    logic              addr_seen [NUM_SETS];
    logic [1:0]        threshold;

    access_t  pending_accesses[$];
    verdict_t expected_verdicts[$];
    int  error_count = 0;
    bit  hold_off = 1'b0;
    int  idle_cycles = 0;

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic void reset_predictor();
        foreach (rrpv_mem[i]) begin
            rrpv_mem[i] = RRPV_MAX;
            blk_sig[i] = '0;
        end
        foreach (reuse_ctr[i]) reuse_ctr[i] = CTR_INIT;
        foreach (prev_addr[i]) begin
            prev_addr[i] = '0;
            stride_cnt[i] = 2'd0;
            addr_seen[i] = 1'b0;
        end
        threshold = 2'd3;
    endfunction

    // applies one access to the predictor and returns the result it should produce
    function automatic verdict_t predict_access(access_t a);
        verdict_t v;
        int base, blk, sbase, old;
        logic [ADDR_W-1:0] delta;
        bit found;
        base = int'(a.set_idx) * NUM_WAYS;
        sbase = int'(a.set_idx) * SIG_ENTRIES;
        v = '0;
        if (a.cmd == CMD_FIND) begin
            found = 0;
            for (int r = 0; r < 4 && !found; r++) begin
                for (int w = 0; w < NUM_WAYS && !found; w++)
                    if (rrpv_mem[base+w] == RRPV_MAX) begin
                        v.victim = w[3:0];
                        found = 1;
                    end
                if (!found)
                    for (int w = 0; w < NUM_WAYS; w++)
                        if (rrpv_mem[base+w] != RRPV_MAX) rrpv_mem[base+w]++;
            end
        end else begin
            delta = (a.addr > prev_addr[a.set_idx]) ? a.addr - prev_addr[a.set_idx]
                                                   : prev_addr[a.set_idx] - a.addr;
            if (addr_seen[a.set_idx] && (delta == STRIDE_SMALL || delta == STRIDE_LARGE)) begin
                if (stride_cnt[a.set_idx] != 2'd3) stride_cnt[a.set_idx]++;
            end else if (stride_cnt[a.set_idx] != 2'd0) begin
                stride_cnt[a.set_idx]--;
            end
            prev_addr[a.set_idx] = a.addr;
            addr_seen[a.set_idx] = 1'b1;
            blk = base + int'(a.way);
            old = sbase + int'(blk_sig[blk]);
            if (a.hit) begin
                rrpv_mem[blk] = 2'd0;
                if (reuse_ctr[old] != CTR_MAX) reuse_ctr[old]++;
            end else begin
                if (reuse_ctr[old] != 2'd0) reuse_ctr[old]--;
                blk_sig[blk] = a.sig;
                rrpv_mem[blk] = (reuse_ctr[sbase + int'(a.sig)] == 2'd0) ? RRPV_MAX : RRPV_NEAR;
            end
        end
        v.streaming = (stride_cnt[a.set_idx] >= threshold);
        return v;
    endfunction

    // driver: pops pending accesses, random gaps between transactions
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the offered transaction
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
            access_t a;
            a = pending_accesses.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= a.cmd;
            s_tdata  <= {2'b00, a.hit, a.sig, a.addr, a.way, a.set_idx};
            expected_verdicts.push_back(predict_access(a));
            send_gap <= gap_len();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver backpressure, with an optional long hold-off
    int recv_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            recv_gap <= gap_len();
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            verdict_t e;
            if (expected_verdicts.size() == 0) begin
                $error("result transaction with no prediction pending: %h", m_tdata);
                error_count++;
            end else begin
                e = expected_verdicts.pop_front();
                if (m_tdata[3:0] !== e.victim) begin
                    $error("victim_way expected %0d actual %0d", e.victim, m_tdata[3:0]);
                    error_count++;
                end
                if (m_tdata[4] !== e.streaming) begin
                    $error("set_streaming expected %0d actual %0d", e.streaming, m_tdata[4]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction (covers the clearing pass)
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_ship_lite_rrip_replacement_top: errors");
            $finish;
        end
    end

    // drains the queues so the block is idle before a register write
    task automatic wait_idle();
        while (pending_accesses.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [1:0] val);
        cfg_wdata <= val;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        threshold = val;
    endtask

    function automatic access_t mk(logic cmd, logic [SET_W-1:0] s, logic [WAY_W-1:0] w,
                                   logic [ADDR_W-1:0] ad, logic [SIG_W-1:0] sg, logic h);
        access_t a;
        a = '{cmd, s, w, ad, sg, h};
        return a;
    endfunction

    // random access: a few hot sets, strided addresses, reuse of signatures
    function automatic access_t rand_access(ref logic [ADDR_W-1:0] walk, input int hot);
        access_t a;
        int k;
        a.cmd = 1'($urandom_range(0, 1));
        a.set_idx = ($urandom_range(0, 3) != 0) ? SET_W'(hot + $urandom_range(0, 3))
                                                 : SET_W'($urandom);
        a.way = WAY_W'($urandom);
        a.sig = ($urandom_range(0, 1) != 0) ? SIG_W'($urandom_range(0, 3)) : SIG_W'($urandom);
        a.hit = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 9);
        if (k < 4) walk = walk + 64;
        else if (k < 6) walk = walk - 128;
        else if (k < 8) walk = {$urandom, $urandom};
        a.addr = walk;
        return a;
    endfunction

    initial begin
        logic [ADDR_W-1:0] walk;
        int hot;
        reset_predictor();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, both commands, hit and miss, stride rule, aging
        pending_accesses.push_back(mk(CMD_FIND, 11'd0, 4'd0, 64'd0, 6'd0, 1'b0));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd0, 4'd0, 64'd0, 6'd63, 1'b0));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd0, 4'd0, 64'd64, 6'd63, 1'b1));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd0, 4'd15, 64'd192, 6'd0, 1'b0));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd0, 4'd15, 64'd128, 6'd0, 1'b1));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd0, 4'd1, 64'd256, 6'd0, 1'b0));
        pending_accesses.push_back(mk(CMD_FIND, 11'd0, 4'd15, '1, 6'd63, 1'b1));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd2047, 4'd15, '1, 6'd63, 1'b1));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFBF,
                                      6'd63, 1'b0));
        pending_accesses.push_back(mk(CMD_UPDATE, 11'd2047, 4'd3, '1, 6'd21, 1'b0));
        pending_accesses.push_back(mk(CMD_FIND, 11'd2047, 4'd0, 64'h5555_5555_5555_5555,
                                      6'd42, 1'b0));
        // make every way of set 5 hit, then find must age three rounds
        for (int w = 0; w < NUM_WAYS; w++)
            pending_accesses.push_back(mk(CMD_UPDATE, 11'd5, w[3:0], 64'hAAAA_AAAA_AAAA_AAAA,
                                          6'd9, 1'b1));
        pending_accesses.push_back(mk(CMD_FIND, 11'd5, 4'd0, 64'd0, 6'd0, 1'b0));
        pending_accesses.push_back(mk(CMD_FIND, 11'd5, 4'd0, 64'd0, 6'd0, 1'b0));
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            write_threshold(phase[1:0]);
            hot = $urandom_range(0, 2040);
            walk = {$urandom, $urandom};
            for (int n = 0; n < 250; n++) pending_accesses.push_back(rand_access(walk, hot));
            if (phase == 1) begin
                // long receiver hold-off while the sender keeps offering
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("tb_ship_lite_rrip_replacement_top: clean");
        else
            $display("tb_ship_lite_rrip_replacement_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
